### design/rto_pkg.sv
// ----------------------------------------------------------------------------
// rto_pkg: shared types and helpers for the rectangle/triangle overlap test
// Holds the three-way sign type and the small sign-algebra helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rto_pkg;

  // Sign of a value: both bits low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  // Sign of a product from the signs of its factors.
  function automatic sign_t sgn_mul(sign_t a, sign_t b);
    sign_t s;
    s.pos = (a.pos & b.pos) | (a.neg & b.neg);
    s.neg = (a.pos & b.neg) | (a.neg & b.pos);
    return s;
  endfunction

  function automatic sign_t sgn_neg(sign_t a);
    sign_t s;
    s.pos = a.neg;
    s.neg = a.pos;
    return s;
  endfunction

  // True when one sign is strictly positive and the other strictly negative.
  function automatic logic sgn_opp(sign_t a, sign_t b);
    return (a.pos & b.neg) | (a.neg & b.pos);
  endfunction

endpackage

`default_nettype wire

### design/rto_cross_sign.sv
// ----------------------------------------------------------------------------
// rto_cross_sign: sign of a 2-D cross product
// Gives the sign of (q - p) x (r - p) for unsigned points p, q and r.
// ----------------------------------------------------------------------------
`default_nettype none

module rto_cross_sign #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0] px,
  input  wire logic [COORD_BITS-1:0] py,
  input  wire logic [COORD_BITS-1:0] qx,
  input  wire logic [COORD_BITS-1:0] qy,
  input  wire logic [COORD_BITS-1:0] rx,
  input  wire logic [COORD_BITS-1:0] ry,
  output rto_pkg::sign_t             sgn
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax, ay, bx, by;
  logic signed [PW-1:0] m1, m2;
  logic signed [PW:0]   v;

  assign ax = $signed({1'b0, qx}) - $signed({1'b0, px});
  assign ay = $signed({1'b0, qy}) - $signed({1'b0, py});
  assign bx = $signed({1'b0, rx}) - $signed({1'b0, px});
  assign by = $signed({1'b0, ry}) - $signed({1'b0, py});

  assign m1 = PW'(ax * by);
  assign m2 = PW'(bx * ay);
  assign v  = $signed({m1[PW-1], m1}) - $signed({m2[PW-1], m2});

  assign sgn.neg = v[PW];
  assign sgn.pos = !v[PW] && (|v);

endmodule

`default_nettype wire

### design/rto_core.sv
// ----------------------------------------------------------------------------
// rto_core: overlap decision for one rectangle and one triangle
// Vertex-in-box, corner-in-triangle and strict edge crossing tests.
// ----------------------------------------------------------------------------
`default_nettype none

module rto_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0] tri_ax,
  input  wire logic [COORD_BITS-1:0] tri_ay,
  input  wire logic [COORD_BITS-1:0] tri_bx,
  input  wire logic [COORD_BITS-1:0] tri_by,
  input  wire logic [COORD_BITS-1:0] tri_cx,
  input  wire logic [COORD_BITS-1:0] tri_cy,
  input  wire logic [COORD_BITS-1:0] box_left,
  input  wire logic [COORD_BITS-1:0] box_top,
  input  wire logic [COORD_BITS-1:0] box_right,
  input  wire logic [COORD_BITS-1:0] box_bottom,
  output logic                       hit
);

  logic [COORD_BITS-1:0] tx [3];
  logic [COORD_BITS-1:0] ty [3];
  logic [COORD_BITS-1:0] kx [4];
  logic [COORD_BITS-1:0] ky [4];

  // Sign of triangle edge i against box corner j.
  rto_pkg::sign_t s_tc [3][4];
  // Sign of box edge j against triangle vertex i.
  rto_pkg::sign_t s_bv [4][3];

  rto_pkg::sign_t dx_rl, dx_lr, dy_bt;
  logic           vert_in, corner_in, edge_x;
  logic           any_pos, any_neg;

  assign tx[0] = tri_ax;
  assign ty[0] = tri_ay;
  assign tx[1] = tri_bx;
  assign ty[1] = tri_by;
  assign tx[2] = tri_cx;
  assign ty[2] = tri_cy;

  // Corners run around the box: (l,t), (r,t), (r,b), (l,b).
  assign kx[0] = box_left;
  assign ky[0] = box_top;
  assign kx[1] = box_right;
  assign ky[1] = box_top;
  assign kx[2] = box_right;
  assign ky[2] = box_bottom;
  assign kx[3] = box_left;
  assign ky[3] = box_bottom;

  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar j = 0; j < 4; j++) begin : g_corner
      rto_cross_sign #(
        .COORD_BITS(COORD_BITS)
      ) u_cross (
        .px (tx[i]),
        .py (ty[i]),
        .qx (tx[(i + 1) % 3]),
        .qy (ty[(i + 1) % 3]),
        .rx (kx[j]),
        .ry (ky[j]),
        .sgn(s_tc[i][j])
      );
    end
  end

  // Box edges are axis aligned, so their cross products reduce to a
  // product of two difference signs and need no multiplier.
  assign dx_rl = '{pos: box_right > box_left, neg: box_right < box_left};
  assign dx_lr = rto_pkg::sgn_neg(dx_rl);
  assign dy_bt = '{pos: box_bottom > box_top, neg: box_bottom < box_top};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_bv[0][i] = rto_pkg::sgn_mul(dx_rl,
                     '{pos: ty[i] > box_top, neg: ty[i] < box_top});
      s_bv[1][i] = rto_pkg::sgn_neg(rto_pkg::sgn_mul(dy_bt,
                     '{pos: tx[i] > box_right, neg: tx[i] < box_right}));
      s_bv[2][i] = rto_pkg::sgn_mul(dx_lr,
                     '{pos: ty[i] > box_bottom, neg: ty[i] < box_bottom});
      s_bv[3][i] = rto_pkg::sgn_mul(dy_bt,
                     '{pos: tx[i] > box_left, neg: tx[i] < box_left});
    end
  end

  always_comb begin
    vert_in   = 1'b0;
    corner_in = 1'b0;
    edge_x    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vert_in |= (tx[i] >= box_left) && (tx[i] <= box_right) &&
                 (ty[i] >= box_top) && (ty[i] <= box_bottom);
    end
    for (int j = 0; j < 4; j++) begin
      any_pos = s_tc[0][j].pos | s_tc[1][j].pos | s_tc[2][j].pos;
      any_neg = s_tc[0][j].neg | s_tc[1][j].neg | s_tc[2][j].neg;
      corner_in |= !(any_pos && any_neg);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        edge_x |= rto_pkg::sgn_opp(s_bv[j][i], s_bv[j][(i + 1) % 3]) &&
                  rto_pkg::sgn_opp(s_tc[i][j], s_tc[i][(j + 1) % 4]);
      end
    end
  end

  assign hit = vert_in | corner_in | edge_x;

endmodule

`default_nettype wire

### design/rect_triangle_overlap_test.sv
// ----------------------------------------------------------------------------
// rect_triangle_overlap_test: rectangle / triangle overlap query engine
// Reports whether an axis-aligned rectangle and a triangle overlap or touch.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Word
//   in       in_valid, in_stall   three vertices, box left/top/right/bottom
//   out      out_valid, out_stall hit
//
// One word is accepted per cycle while in_stall is low; it passes through
// the input register and then the result register, the two stages.
// The cross products in rto_core sit between those registers and set the
// clock period; there is no other state.
// Reset empties both stages. A stalled result holds while the input stage
// still takes one more word, and in_stall rises only when both stages are full.
`default_nettype none

module rect_triangle_overlap_test #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_tri_ax,
  input  wire logic [COORD_BITS-1:0] in_tri_ay,
  input  wire logic [COORD_BITS-1:0] in_tri_bx,
  input  wire logic [COORD_BITS-1:0] in_tri_by,
  input  wire logic [COORD_BITS-1:0] in_tri_cx,
  input  wire logic [COORD_BITS-1:0] in_tri_cy,
  input  wire logic [COORD_BITS-1:0] in_box_left,
  input  wire logic [COORD_BITS-1:0] in_box_top,
  input  wire logic [COORD_BITS-1:0] in_box_right,
  input  wire logic [COORD_BITS-1:0] in_box_bottom,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit
);

  logic                  s1_vld_r, s1_vld_nxt;
  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [COORD_BITS-1:0] left_r, top_r, right_r, bottom_r;
  logic                  out_vld_r, out_vld_nxt;
  logic                  hit_r;
  logic                  hit_comb;
  logic                  out_adv, s1_en;

  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_en    = !s1_vld_r || out_adv;
  assign in_stall = !s1_en;

  assign s1_vld_nxt  = s1_en ? in_valid : s1_vld_r;
  assign out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_en) begin
      ax_r     <= in_tri_ax;
      ay_r     <= in_tri_ay;
      bx_r     <= in_tri_bx;
      by_r     <= in_tri_by;
      cx_r     <= in_tri_cx;
      cy_r     <= in_tri_cy;
      left_r   <= in_box_left;
      top_r    <= in_box_top;
      right_r  <= in_box_right;
      bottom_r <= in_box_bottom;
    end
  end

  rto_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .tri_ax    (ax_r),
    .tri_ay    (ay_r),
    .tri_bx    (bx_r),
    .tri_by    (by_r),
    .tri_cx    (cx_r),
    .tri_cy    (cy_r),
    .box_left  (left_r),
    .box_top   (top_r),
    .box_right (right_r),
    .box_bottom(bottom_r),
    .hit       (hit_comb)
  );

  always_ff @(posedge clk) begin
    if (s1_vld_r && out_adv) begin
      hit_r <= hit_comb;
    end
  end

  assign out_valid = out_vld_r;
  assign out_hit   = hit_r;

endmodule

`default_nettype wire
